// ----- src/ibo_pkg.sv -----
// shared constants, types and codes for the scaled int8 binary operation
package ibo_pkg;

    // fixed point format of the scale registers
    localparam int SCALE_FRAC_BITS = 16;
    localparam int SCALE_W         = 24;
    localparam int BYTE_W          = 8;

    // operand value after typing: s8 or u8 both fit in nine signed bits
    localparam int VAL_W  = BYTE_W + 1;
    // scaled operand
    localparam int PROD_W = VAL_W + SCALE_W;
    // product of two scaled operands
    localparam int MUL_W  = 2 * PROD_W;
    // sum, maximum or minimum of two scaled operands
    localparam int SUM_W  = PROD_W + 1;
    // accumulator at twice the fractional bits
    localparam int ACC_W  = ((MUL_W > SUM_W + SCALE_FRAC_BITS + 1) ?
                             MUL_W : (SUM_W + SCALE_FRAC_BITS + 1)) + 1;
    // integer part of the accumulator
    localparam int Q_W    = ACC_W - 2 * SCALE_FRAC_BITS;

    localparam int CFG_IDX_W = 3;

    // reset values of the scale registers
    localparam logic signed [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1 << SCALE_FRAC_BITS);
    localparam logic signed [SCALE_W-1:0] SCALE_ZERO = '0;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_MAX = 2'd2,
        OP_MIN = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPERATION        = 3'd0,
        CFG_FIRST_IS_SIGNED  = 3'd1,
        CFG_SECOND_IS_SIGNED = 3'd2,
        CFG_FIRST_SCALE      = 3'd3,
        CFG_SECOND_SCALE     = 3'd4,
        CFG_SUM_SCALE        = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_op                       operation;
        logic                      first_is_signed;
        logic                      second_is_signed;
        logic signed [SCALE_W-1:0] first_scale;
        logic signed [SCALE_W-1:0] second_scale;
        logic signed [SCALE_W-1:0] sum_scale;
    } t_cfg;

    // scaled terms handed from the multiplier stages to the rounding stages
    typedef struct packed {
        t_op                      operation;
        logic                     first_is_signed;
        logic signed [MUL_W-1:0]  product;
        logic signed [SUM_W-1:0]  combined;
        logic signed [PROD_W-1:0] prior_term;
    } t_terms;

endpackage

// ----- src/ibo_cfg_regs.sv -----
// configuration register file
module ibo_cfg_regs
    import ibo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.operation        <= OP_ADD;
            r_cfg.first_is_signed  <= 1'b0;
            r_cfg.second_is_signed <= 1'b0;
            r_cfg.first_scale      <= SCALE_ONE;
            r_cfg.second_scale     <= SCALE_ONE;
            r_cfg.sum_scale        <= SCALE_ZERO;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OPERATION:        r_cfg.operation        <= t_op'(i_cfg_data[1:0]);
                CFG_FIRST_IS_SIGNED:  r_cfg.first_is_signed  <= i_cfg_data[0];
                CFG_SECOND_IS_SIGNED: r_cfg.second_is_signed <= i_cfg_data[0];
                CFG_FIRST_SCALE:      r_cfg.first_scale      <= $signed(i_cfg_data);
                CFG_SECOND_SCALE:     r_cfg.second_scale     <= $signed(i_cfg_data);
                CFG_SUM_SCALE:        r_cfg.sum_scale        <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ----- src/ibo_mult.sv -----
// operand scaling and combining stages (two register stages)
module ibo_mult
    import ibo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_first_byte,
    input  logic [BYTE_W-1:0] i_second_byte,
    input  logic [BYTE_W-1:0] i_prior_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output t_terms            o_terms
);

    logic                     r_v1;
    t_op                      r_op1;
    logic                     r_fs1;
    logic signed [PROD_W-1:0] r_a;
    logic signed [PROD_W-1:0] r_b;
    logic signed [PROD_W-1:0] r_p;
    logic                     r_v2;
    t_terms                   r_terms;

    logic                     rdy1;
    logic                     rdy2;
    logic signed [VAL_W-1:0]  va;
    logic signed [VAL_W-1:0]  vb;
    logic signed [VAL_W-1:0]  vp;
    logic signed [PROD_W-1:0] n_a;
    logic signed [PROD_W-1:0] n_b;
    logic signed [PROD_W-1:0] n_p;
    t_terms                   n_terms;

    // stage ready chain
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // stage 1: type the bytes and apply their scales
    always_comb begin
        va  = $signed({i_cfg.first_is_signed  & i_first_byte[BYTE_W-1],  i_first_byte});
        vb  = $signed({i_cfg.second_is_signed & i_second_byte[BYTE_W-1], i_second_byte});
        vp  = $signed({i_cfg.first_is_signed  & i_prior_byte[BYTE_W-1],  i_prior_byte});
        n_a = PROD_W'(va) * PROD_W'(i_cfg.first_scale);
        n_b = PROD_W'(vb) * PROD_W'(i_cfg.second_scale);
        // a zero sum scale yields a zero term
        n_p = PROD_W'(vp) * PROD_W'(i_cfg.sum_scale);
    end

    // stage 2: product and the add / max / min alternative
    always_comb begin
        n_terms.operation       = r_op1;
        n_terms.first_is_signed = r_fs1;
        n_terms.product         = MUL_W'(r_a) * MUL_W'(r_b);
        n_terms.prior_term      = r_p;
        case (r_op1)
            OP_ADD:  n_terms.combined = SUM_W'(r_a) + SUM_W'(r_b);
            OP_MAX:  n_terms.combined = (r_a > r_b) ? SUM_W'(r_a) : SUM_W'(r_b);
            OP_MIN:  n_terms.combined = (r_a < r_b) ? SUM_W'(r_a) : SUM_W'(r_b);
            default: n_terms.combined = '0;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_op1 <= i_cfg.operation;
            r_fs1 <= i_cfg.first_is_signed;
            r_a   <= n_a;
            r_b   <= n_b;
            r_p   <= n_p;
        end
        if (rdy2) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_v2;
    assign o_terms = r_terms;

    // a full first stage moves on when the second can take it
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && rdy2 |=> r_v2)
        else $error("stage 1 transaction lost");

    // a stalled second stage keeps its terms
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_ready |=> r_v2 && $stable(r_terms))
        else $error("stage 2 terms changed under stall");

    // an empty first stage with no incoming transaction stays empty
    a_s1_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 && !i_valid |=> !r_v1)
        else $error("stage 1 filled without a transaction");

endmodule

// ----- src/ibo_round.sv -----
// accumulate, round half to even and saturate (three register stages)
module ibo_round
    import ibo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_terms            i_terms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_result_byte
);

    localparam int FB2 = 2 * SCALE_FRAC_BITS;

    logic                    r_v3;
    logic                    r_fs3;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_v4;
    logic                    r_fs4;
    logic signed [Q_W-1:0]   r_q;
    logic                    r_up;
    logic                    r_v5;
    logic [BYTE_W-1:0]       r_res;

    logic                    rdy3;
    logic                    rdy4;
    logic                    rdy5;
    logic signed [ACC_W-1:0] main_term;
    logic signed [ACC_W-1:0] prior_term;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [Q_W-1:0]   n_q;
    logic                    n_up;
    logic signed [Q_W-1:0]   qr;
    logic signed [Q_W-1:0]   lo;
    logic signed [Q_W-1:0]   hi;
    logic [BYTE_W-1:0]       n_res;

    // stage ready chain
    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    // stage 3: bring all terms to double fractional bits and add
    always_comb begin
        if (i_terms.operation == OP_MUL) begin
            main_term = ACC_W'(i_terms.product);
        end else begin
            main_term = ACC_W'(i_terms.combined) <<< SCALE_FRAC_BITS;
        end
        prior_term = ACC_W'(i_terms.prior_term) <<< SCALE_FRAC_BITS;
        n_acc      = main_term + prior_term;
    end

    // stage 4: floor and the round up decision, ties go to even
    always_comb begin
        n_q  = $signed(r_acc[ACC_W-1:FB2]);
        n_up = r_acc[FB2-1] && ((|r_acc[FB2-2:0]) || r_acc[FB2]);
    end

    // stage 5: apply rounding and clamp to the result type
    always_comb begin
        qr = r_q + $signed({{(Q_W-1){1'b0}}, r_up});
        lo = r_fs4 ? Q_W'(-128) : Q_W'(0);
        hi = r_fs4 ? Q_W'(127)  : Q_W'(255);
        if (qr < lo) begin
            n_res = lo[BYTE_W-1:0];
        end else if (qr > hi) begin
            n_res = hi[BYTE_W-1:0];
        end else begin
            n_res = qr[BYTE_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_acc <= n_acc;
            r_fs3 <= i_terms.first_is_signed;
        end
        if (rdy4) begin
            r_q   <= n_q;
            r_up  <= n_up;
            r_fs4 <= r_fs3;
        end
        if (rdy5) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_v5;
    assign o_result_byte = r_res;

    // a full accumulator stage moves on when rounding can take it
    a_s3_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && rdy4 |=> r_v4)
        else $error("accumulator transaction lost");

    // rounding stage holds while the output register is stalled
    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !rdy5 |=> r_v4 && $stable(r_q) && $stable(r_up))
        else $error("rounding stage changed under stall");

    // output register keeps its result until taken
    a_s5_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !i_ready |=> r_v5 && $stable(r_res))
        else $error("result changed under stall");

endmodule

// ----- src/int8_scaled_binary_op.sv -----
// top level of the scaled int8 element-wise binary operation
//
// Input channel: one transaction carries a first, second and prior destination
// byte (i_in_valid / o_in_ready). Output channel: one result byte per input
// transaction, in order (o_out_valid / i_out_ready). Configuration channel:
// register index and data (i_cfg_valid / o_cfg_ready), always ready; the user
// must make writes only while no transaction is in flight, as the block does
// not enforce it. Each result is registered through a five stage pipeline
// (scale multiply, product and combine, accumulate, round, clamp), which takes
// one transaction per cycle while the output is not stalled.
// Reset empties every stage and loads the register defaults: add, unsigned
// operands, unit scales and no sum term.
// When the receiver stalls, the stalled result and every stage behind it hold;
// empty stages ahead of the stall still fill, so up to five transactions are
// taken before o_in_ready falls. Nothing is dropped or repeated.
module int8_scaled_binary_op
    import ibo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_first_byte,
    input  logic [BYTE_W-1:0]    i_second_byte,
    input  logic [BYTE_W-1:0]    i_prior_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_result_byte
);

    t_cfg   cfg;
    t_terms terms;
    logic   terms_valid;
    logic   terms_ready;

    // configuration registers
    ibo_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // scaling and combining
    ibo_mult u_mult (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .i_prior_byte  (i_prior_byte),
        .o_valid       (terms_valid),
        .i_ready       (terms_ready),
        .o_terms       (terms)
    );

    // accumulate, round and saturate
    ibo_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (terms_valid),
        .o_ready       (terms_ready),
        .i_terms       (terms),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_result_byte (o_result_byte)
    );

endmodule
